// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define PMTI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmti assertion failed");

// Next-cycle implication, clocked on clk, quiet during reset.
`define PMTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmti assertion failed");

`endif

// ----- rtl/pmti_pkg.sv -----
// Package: types and constants of the polygon mesh triangle index generator.
`default_nettype none
package pmti_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIDES        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBDIVISIONS = 2'd1;

  localparam logic [4:0] MIN_SIDES        = 5'd3;
  localparam logic [4:0] QUAD_SIDES       = 5'd4;
  localparam logic [4:0] MAX_SIDES        = 5'd16;
  localparam logic [6:0] MAX_SUBDIVISIONS = 7'd64;

  localparam logic [4:0] SIDES_RESET  = 5'd3;
  localparam logic [6:0] SUBDIV_RESET = 7'd1;

  typedef enum logic [1:0] {
    MODE_TRI  = 2'd0,
    MODE_QUAD = 2'd1,
    MODE_RING = 2'd2
  } mode_t;

  typedef struct packed {
    logic [6:0]  outer_counter;
    logic [4:0]  side_counter;
    logic [6:0]  inner_counter;
    logic        second_half;
    logic [15:0] previous_row_base;
    logic [15:0] current_row_base;
    logic [15:0] inner_vertex;
    logic [15:0] outer_vertex;
    logic        finished;
  } mesh_st_t;

  typedef struct packed {
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic        valid_res;
    logic        last_triangle;
  } tri_res_t;

endpackage
`default_nettype wire

// ----- rtl/pmti_step.sv -----
// Next-state and triangle logic for one request.
`default_nettype none
module pmti_step import pmti_pkg::*; (
  input  mesh_st_t   st,
  input  logic       restart,
  input  logic [4:0] sides,
  input  logic [6:0] subdivisions,
  output mesh_st_t   st_next,
  output tri_res_t   res
);

  logic [4:0]  n;
  logic [6:0]  r;
  logic [6:0]  r1;
  mode_t       mode;
  mesh_st_t    s;
  logic [6:0]  i;
  logic [6:0]  j;
  logic [7:0]  i_inc;
  logic [7:0]  j_inc;
  logic [13:0] prod;
  logic [15:0] idx;
  logic [15:0] cj;
  logic [15:0] pj;
  logic [15:0] ov1;
  logic [15:0] inext;
  logic        last_side;
  logic        wrap;
  logic        last;
  logic [15:0] v0;
  logic [15:0] v1;
  logic [15:0] v2;

  // clamp registers into range
  always_comb begin
    if (sides < MIN_SIDES) begin
      n = MIN_SIDES;
    end else if (sides > MAX_SIDES) begin
      n = MAX_SIDES;
    end else begin
      n = sides;
    end
    r  = (subdivisions > MAX_SUBDIVISIONS) ? MAX_SUBDIVISIONS : subdivisions;
    r1 = r + 7'd1;
    if (n == MIN_SIDES) begin
      mode = MODE_TRI;
    end else if (n == QUAD_SIDES) begin
      mode = MODE_QUAD;
    end else begin
      mode = MODE_RING;
    end
  end

  always_comb begin
    s = st;
    if (restart) begin
      s = '0;
      s.current_row_base = 16'd1;
      s.outer_vertex     = 16'd1;
      if (mode == MODE_RING) begin
        s.outer_counter = 7'd1;
      end
    end
    if (r == 7'd0) begin
      s.finished = 1'b1;
    end

    i     = s.outer_counter;
    j     = s.inner_counter;
    i_inc = {1'b0, i} + 8'd1;
    j_inc = {1'b0, j} + 8'd1;
    prod  = {7'd0, i} * {7'd0, r1};
    idx   = 16'(prod) + 16'(j);
    cj    = s.current_row_base + 16'(j);
    pj    = s.previous_row_base + 16'(j);
    ov1   = s.outer_vertex + 16'd1;
    last_side = ({1'b0, s.side_counter} + 6'd1) >= {1'b0, n};
    wrap      = last_side && (j_inc >= {1'b0, i});
    inext     = wrap ? s.previous_row_base : s.inner_vertex + 16'd1;

    st_next = s;
    last    = 1'b0;
    v0      = '0;
    v1      = '0;
    v2      = '0;

    case (mode)
      MODE_TRI: begin
        if (j < i) begin
          if (!s.second_half) begin
            v0 = cj;
            v1 = cj + 16'd1;
            v2 = pj;
            st_next.second_half = 1'b1;
          end else begin
            v0 = cj + 16'd1;
            v1 = pj + 16'd1;
            v2 = pj;
            st_next.second_half   = 1'b0;
            st_next.inner_counter = j_inc[6:0];
          end
        end else begin
          // closing triangle of the row
          v0 = s.current_row_base + 16'(i);
          v1 = s.current_row_base + 16'(i) + 16'd1;
          v2 = s.previous_row_base + 16'(i);
          st_next.previous_row_base = s.current_row_base;
          st_next.current_row_base  = s.current_row_base + 16'(i) + 16'd2;
          st_next.outer_counter     = i_inc[6:0];
          st_next.inner_counter     = 7'd0;
          st_next.second_half       = 1'b0;
          last = i_inc >= {1'b0, r};
        end
      end
      MODE_QUAD: begin
        if (!s.second_half) begin
          v0 = idx;
          v1 = idx + 16'(r1);
          v2 = idx + 16'd1;
          st_next.second_half = 1'b1;
        end else begin
          v0 = idx + 16'd1;
          v1 = idx + 16'(r1);
          v2 = idx + 16'(r1) + 16'd1;
          st_next.second_half = 1'b0;
          if (j_inc >= {1'b0, r}) begin
            st_next.inner_counter = 7'd0;
            st_next.outer_counter = i_inc[6:0];
            last = i_inc >= {1'b0, r};
          end else begin
            st_next.inner_counter = j_inc[6:0];
          end
        end
      end
      MODE_RING: begin
        if (!s.second_half) begin
          v0 = s.inner_vertex;
          v1 = s.outer_vertex;
          v2 = wrap ? s.current_row_base : ov1;
          st_next.outer_vertex = ov1;
          if (j_inc >= {1'b0, i}) begin
            st_next.inner_counter = 7'd0;
            if (last_side) begin
              // layer closes: next ring starts after this one
              last = i >= r;
              st_next.previous_row_base = s.current_row_base;
              st_next.inner_vertex      = s.current_row_base;
              st_next.current_row_base  = ov1;
              st_next.outer_counter     = i_inc[6:0];
              st_next.side_counter      = 5'd0;
            end else begin
              st_next.side_counter = s.side_counter + 5'd1;
            end
          end else begin
            st_next.inner_counter = j_inc[6:0];
            st_next.second_half   = 1'b1;
          end
        end else begin
          v0 = s.inner_vertex;
          v1 = s.outer_vertex;
          v2 = inext;
          st_next.inner_vertex = inext;
          st_next.second_half  = 1'b0;
        end
      end
      default: begin
        st_next = s;
      end
    endcase

    res = '0;
    if (s.finished) begin
      st_next = s;
    end else begin
      if (last) begin
        st_next.finished = 1'b1;
      end
      res.vertex_a      = v0;
      res.vertex_b      = v1;
      res.vertex_c      = v2;
      res.valid_res     = 1'b1;
      res.last_triangle = last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/polygon_mesh_triangle_indices_top.sv -----
// Top level: polygon mesh triangle index generator with output register.
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | restart
// out      | out_valid / out_ready| vertex_a, vertex_b, vertex_c, valid_res,
//          |                      | last_triangle
// cfg      | cfg_valid / cfg_ready| cfg_index (0 sides, 1 subdivisions), cfg_data
//
// One request beat in, one result beat out.
// Throughput is one beat per cycle: the mesh counters update in a single
// pass of pmti_step between the state registers and the result register.
// in_ready drops only while a result sits in the output register and
// out_ready is low; the result register and mesh state then hold.
// Reset: sides 3, subdivisions 1, no mesh active (results invalid until
// a restart beat). cfg_ready is always high.
`default_nettype none
module polygon_mesh_triangle_indices_top import pmti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          vertex_a,
  output logic [15:0]          vertex_b,
  output logic [15:0]          vertex_c,
  output logic                 valid_res,
  output logic                 last_triangle,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [4:0] sides;
  logic [6:0] subdivisions;
  mesh_st_t   st;
  mesh_st_t   st_next;
  tri_res_t   res_next;
  tri_res_t   res;
  logic       in_fire;

  // output register frees up when its beat is taken
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      sides        <= SIDES_RESET;
      subdivisions <= SUBDIV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIDES:        sides        <= cfg_data[4:0];
        REG_SUBDIVISIONS: subdivisions <= cfg_data[6:0];
        default:          ;
      endcase
    end
  end

  pmti_step u_step (
    .st           (st),
    .restart      (restart),
    .sides        (sides),
    .subdivisions (subdivisions),
    .st_next      (st_next),
    .res          (res_next)
  );

  // mesh state advances once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{finished: 1'b1, default: '0};
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign vertex_a      = res.vertex_a;
  assign vertex_b      = res.vertex_b;
  assign vertex_c      = res.vertex_c;
  assign valid_res     = res.valid_res;
  assign last_triangle = res.last_triangle;

endmodule
`default_nettype wire

// ----- rtl/pmti_checker.sv -----
// Port-level checker for the polygon mesh triangle index generator, with bind.
`default_nettype none
`include "assert_macros.svh"
module pmti_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] vertex_a,
  input logic [15:0] vertex_b,
  input logic [15:0] vertex_c,
  input logic        valid_res,
  input logic        last_triangle
);

  // an empty result carries all-zero fields
  `PMTI_ASSERT_NOW(a_empty_zero, out_valid && !valid_res,
    vertex_a == 16'd0 && vertex_b == 16'd0 && vertex_c == 16'd0 && !last_triangle)

  // final flag only on a real triangle
  `PMTI_ASSERT_NOW(a_last_valid, out_valid && last_triangle, valid_res)

  // an empty output register never back-pressures requests
  `PMTI_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

  // a stalled result beat holds
  `PMTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(vertex_a) && $stable(vertex_b) && $stable(vertex_c) &&
    $stable(valid_res) && $stable(last_triangle))

endmodule

bind polygon_mesh_triangle_indices_top pmti_checker u_pmti_checker (.*);
`default_nettype wire

// ----- tb/tb_polygon_mesh_triangle_indices_top.sv -----
// Self-checking testbench for the polygon mesh triangle index generator.
module tb_polygon_mesh_triangle_indices_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pmti_pkg::*;

  // Register indexes the block has no register behind; beats there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned RANDOM_REQUESTS = 1950;
  localparam int unsigned MAX_WAIT        = 12;
  localparam int unsigned LONG_HOLD       = 200;   // receiver hold-off, in cycles

  // ---------------------------------------------------------------- DUT ports
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 restart   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          vertex_a;
  logic [15:0]          vertex_b;
  logic [15:0]          vertex_c;
  logic                 valid_res;
  logic                 last_triangle;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  polygon_mesh_triangle_indices_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .vertex_c      (vertex_c),
    .valid_res     (valid_res),
    .last_triangle (last_triangle),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------ shared state
  // Requests waiting to be offered: restart bit of each beat.
  bit          restart_q[$];
  tri_res_t    expected_tris[$];
  int unsigned requests_queued = 0;
  int unsigned requests_taken  = 0;
  int unsigned triangles_seen  = 0;
  int unsigned mismatches      = 0;

  // Beats taken at the last rising edge, seen by the falling-edge drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic cfg_taken = 1'b0;

  // Idle levels: 0 gives back-to-back beats, 3 idles on most beats.
  int unsigned in_level  = 0;
  int unsigned out_level = 0;
  int unsigned in_gap    = 0;
  int unsigned rx_wait   = 0;

  // Long receiver hold-off, requested by the stimulus, counted below.
  bit          hold_rx_req   = 1'b0;
  logic        rx_hold       = 1'b0;
  int unsigned rx_hold_count = 0;

  // Predictor copy of the registers and the mesh walk.
  logic [4:0] sides_cfg  = SIDES_RESET;
  logic [6:0] subdiv_cfg = SUBDIV_RESET;
  mesh_st_t   mesh_st    = '{finished: 1'b1, default: '0};

  function automatic int unsigned draw_wait(int unsigned level);
    if (level == 0) return 0;
    return ($urandom_range(0, 3) < level) ? $urandom_range(1, MAX_WAIT) : 0;
  endfunction

  // Next triangle of the mesh for one request beat; updates the mesh walk.
  function automatic tri_res_t next_triangle(logic rs);
    int unsigned n, r, i, j, p, c, side, vert, nxt, va, vb, vc;
    logic        last, last_side, wrap;
    mode_t       mode;
    tri_res_t    res;
    res  = '0;
    va   = 0;
    vb   = 0;
    vc   = 0;
    last = 1'b0;
    n = 32'(sides_cfg);
    if (n < 32'(MIN_SIDES)) n = 32'(MIN_SIDES);
    if (n > 32'(MAX_SIDES)) n = 32'(MAX_SIDES);
    r = 32'(subdiv_cfg);
    if (r > 32'(MAX_SUBDIVISIONS)) r = 32'(MAX_SUBDIVISIONS);
    if (rs) begin
      mesh_st = '0;
      mesh_st.current_row_base = 16'd1;
      mesh_st.outer_vertex     = 16'd1;
      if (n > 32'(QUAD_SIDES)) mesh_st.outer_counter = 7'd1;
    end
    if (r == 0) mesh_st.finished = 1'b1;
    if (mesh_st.finished) return res;

    mode = (n == 32'(MIN_SIDES)) ? MODE_TRI : (n == 32'(QUAD_SIDES)) ? MODE_QUAD : MODE_RING;
    i    = 32'(mesh_st.outer_counter);
    j    = 32'(mesh_st.inner_counter);
    p    = 32'(mesh_st.previous_row_base);
    c    = 32'(mesh_st.current_row_base);
    case (mode)
      MODE_TRI: begin
        if (j < i) begin
          // pairs along the row, then the closing triangle
          if (!mesh_st.second_half) begin
            va = c + j;
            vb = c + j + 1;
            vc = p + j;
            mesh_st.second_half = 1'b1;
          end else begin
            va = c + j + 1;
            vb = p + j + 1;
            vc = p + j;
            mesh_st.second_half   = 1'b0;
            mesh_st.inner_counter = 7'(j + 1);
          end
        end else begin
          va = c + i;
          vb = c + i + 1;
          vc = p + i;
          mesh_st.previous_row_base = 16'(c);
          mesh_st.current_row_base  = 16'(c + i + 2);
          mesh_st.outer_counter     = 7'(i + 1);
          mesh_st.inner_counter     = '0;
          mesh_st.second_half       = 1'b0;
          last = (i + 1 >= r);
        end
      end
      MODE_QUAD: begin
        nxt = i * (r + 1) + j;
        if (!mesh_st.second_half) begin
          va = nxt;
          vb = nxt + r + 1;
          vc = nxt + 1;
          mesh_st.second_half = 1'b1;
        end else begin
          va = nxt + 1;
          vb = nxt + r + 1;
          vc = nxt + r + 2;
          mesh_st.second_half = 1'b0;
          if (j + 1 >= r) begin
            mesh_st.inner_counter = '0;
            mesh_st.outer_counter = 7'(i + 1);
            last = (i + 1 >= r);
          end else begin
            mesh_st.inner_counter = 7'(j + 1);
          end
        end
      end
      default: begin
        // rings: i is the layer, j the step along the current side
        side      = 32'(mesh_st.side_counter);
        vert      = j;
        last_side = (side + 1 >= n);
        wrap      = last_side && (vert + 1 >= i);
        if (!mesh_st.second_half) begin
          nxt = wrap ? c : 32'(mesh_st.outer_vertex) + 1;
          va  = 32'(mesh_st.inner_vertex);
          vb  = 32'(mesh_st.outer_vertex);
          vc  = nxt;
          mesh_st.outer_vertex = mesh_st.outer_vertex + 16'd1;
          vert = vert + 1;
          if (vert >= i) begin
            mesh_st.inner_counter = '0;
            if (last_side) begin
              last = (i >= r);
              mesh_st.previous_row_base = 16'(c);
              mesh_st.inner_vertex      = 16'(c);
              mesh_st.current_row_base  = mesh_st.outer_vertex;
              mesh_st.outer_counter     = 7'(i + 1);
              mesh_st.side_counter      = '0;
            end else begin
              mesh_st.side_counter = 5'(side + 1);
            end
          end else begin
            mesh_st.inner_counter = 7'(vert);
            mesh_st.second_half   = 1'b1;
          end
        end else begin
          nxt = wrap ? p : 32'(mesh_st.inner_vertex) + 1;
          va  = 32'(mesh_st.inner_vertex);
          vb  = 32'(mesh_st.outer_vertex);
          vc  = nxt;
          mesh_st.inner_vertex = 16'(nxt);
          mesh_st.second_half  = 1'b0;
        end
      end
    endcase
    if (last) mesh_st.finished = 1'b1;
    res.vertex_a      = 16'(va);
    res.vertex_b      = 16'(vb);
    res.vertex_c      = 16'(vc);
    res.valid_res     = 1'b1;
    res.last_triangle = last;
    return res;
  endfunction

  // ------------------------------------------------------- request driver
  // Offers the next queued request after its drawn idle gap; holds the beat
  // until taken.
  always @(negedge clk) begin : drive_requests
    logic offer;
    offer = in_valid && !in_taken;
    if (!rst && !offer) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (restart_q.size() != 0) begin
        restart <= restart_q.pop_front();
        offer   = 1'b1;
        in_gap  = draw_wait(in_level);
      end
    end
    in_valid <= offer;
  end

  // ------------------------------------------------------ result receiver
  // Draws a wait per result beat; the long hold-off overrides it.
  always @(negedge clk) begin : drive_ready
    if (out_taken) rx_wait = draw_wait(out_level);
    if (rst || rx_hold) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Counts the long hold-off while it is requested.
  always @(negedge clk) begin : count_hold
    if (!hold_rx_req) begin
      rx_hold       <= 1'b0;
      rx_hold_count <= 0;
    end else if (rx_hold_count < LONG_HOLD) begin
      rx_hold       <= 1'b1;
      rx_hold_count <= rx_hold_count + 1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  // --------------------------------------------------------------- monitor
  // Samples every beat at the rising edge: register writes update the
  // predictor, requests add an expected triangle, results are checked.
  always @(posedge clk) begin : watch_beats
    tri_res_t got, want;
    in_taken  <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIDES:        sides_cfg  = cfg_data[4:0];
          REG_SUBDIVISIONS: subdiv_cfg = cfg_data[6:0];
          default: ;
        endcase
      end
      // check first: a result can never stem from a request taken on the same edge
      if (out_valid && out_ready) begin
        got = {vertex_a, vertex_b, vertex_c, valid_res, last_triangle};
        triangles_seen++;
        if (expected_tris.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result beat %0d with nothing expected:",
                      " a=%0d b=%0d c=%0d valid=%0b last=%0b"},
                     triangles_seen, got.vertex_a, got.vertex_b, got.vertex_c,
                     got.valid_res, got.last_triangle);
        end else begin
          want = expected_tris.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result beat %0d: expected a=%0d b=%0d c=%0d valid=%0b last=%0b,",
                        " got a=%0d b=%0d c=%0d valid=%0b last=%0b"},
                       triangles_seen, want.vertex_a, want.vertex_b, want.vertex_c,
                       want.valid_res, want.last_triangle, got.vertex_a, got.vertex_b,
                       got.vertex_c, got.valid_res, got.last_triangle);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_tris.insert(expected_tris.size(), next_triangle(restart));
        requests_taken++;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic queue_request(bit rs);
    restart_q.insert(restart_q.size(), rs);
    requests_queued++;
  endtask

  // One register beat, held until taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Sender pauses until every request is taken and every triangle is back;
  // returns on a rising edge so the queue is filled away from the driver.
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_taken != requests_queued || expected_tris.size() != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned pick_sides, pick_subdiv, n, r, mesh_size, count, phase, random_sent;
    bit          lead_restart, noisy;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: nothing active after reset, then the smallest mesh of each mode,
    // out-of-range registers and a mode change in the middle of a mesh.
    in_level  = 1;
    out_level = 1;
    queue_request(1'b0);        // no mesh yet: invalid result
    queue_request(1'b1);        // default single triangle, flagged last
    queue_request(1'b0);        // past the end: invalid
    wait_idle();
    write_reg(REG_SIDES, 16'd4);
    write_reg(REG_SUBDIVISIONS, 16'd1);
    @(posedge clk);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    wait_idle();
    write_reg(REG_SIDES, 16'd5);  // one ring, wrap on the last side
    @(posedge clk);
    queue_request(1'b1);
    repeat (4) queue_request(1'b0);
    wait_idle();
    write_reg(REG_SIDES, 16'd2);  // below three acts as a triangle
    write_reg(REG_SUBDIVISIONS, 16'd2);
    @(posedge clk);
    queue_request(1'b1);
    repeat (3) queue_request(1'b0);
    wait_idle();
    write_reg(REG_SIDES, 16'hFFFF);       // 31 sides, clamped
    write_reg(REG_SUBDIVISIONS, 16'h0000);  // empty mesh
    @(posedge clk);
    queue_request(1'b1);
    queue_request(1'b0);
    wait_idle();
    write_reg(REG_SIDES, 16'd16);
    write_reg(REG_SUBDIVISIONS, 16'hFFFF);  // 127, clamped to the maximum
    @(posedge clk);
    queue_request(1'b1);
    repeat (3) queue_request(1'b0);
    wait_idle();
    write_reg(REG_SIDES, 16'h0000);      // ring walk carries on as a triangle
    write_reg(REG_SUBDIVISIONS, 16'd64);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    @(posedge clk);
    queue_request(1'b0);
    queue_request(1'b0);

    // Random: mostly whole meshes from a restart to just past the last
    // triangle, some carrying on an earlier walk, some with stray restarts.
    pick_sides  = 0;
    pick_subdiv = 0;
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      wait_idle();
      in_level     = $urandom_range(0, 3);
      out_level    = $urandom_range(0, 3);
      lead_restart = ($urandom_range(0, 5) != 0);
      noisy        = ($urandom_range(0, 3) == 0);
      if (phase == 0 || $urandom_range(0, 4) != 0) begin
        pick_sides = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(3, 16);
        case ($urandom_range(0, 19))
          0:                       pick_subdiv = 0;
          1, 2, 3, 4, 5, 6, 7, 8,
          9, 10, 11, 12, 13, 14, 15: pick_subdiv = $urandom_range(1, 4);
          16, 17, 18:              pick_subdiv = $urandom_range(5, 12);
          default:                 pick_subdiv = $urandom_range(13, 127);
        endcase
        write_reg(REG_SIDES, {11'($urandom), 5'(pick_sides)});
        write_reg(REG_SUBDIVISIONS, {9'($urandom), 7'(pick_subdiv)});
        if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE_B, 16'($urandom));
      end
      @(posedge clk);

      n = (pick_sides < 3) ? 3 : (pick_sides > 16) ? 16 : pick_sides;
      r = (pick_subdiv > 64) ? 64 : pick_subdiv;
      mesh_size = (n == 3) ? r * r : (n == 4) ? 2 * r * r : n * r * r;
      if (lead_restart && mesh_size <= 70) count = mesh_size + $urandom_range(0, 2);
      else                                 count = $urandom_range(10, 70);

      // block fills up behind a long receiver hold-off
      if (phase == 3 || phase == 17) begin
        in_level = 0;
        if (count < 20) count = 20;
      end

      if (lead_restart) queue_request(1'b1);
      repeat (count) queue_request(noisy && $urandom_range(0, 15) == 0);
      random_sent += count + (lead_restart ? 1 : 0);

      if (phase == 3 || phase == 17) begin
        hold_rx_req = 1'b1;
        do @(posedge clk); while (rx_hold_count != LONG_HOLD);
        hold_rx_req = 1'b0;
      end
      phase++;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_tris.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : run_limit
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
